### rtl/core/bilinear_cover_crop_scaler_core_defines.svh
// Assertion macros shared by the scaler core.
`ifndef BILINEAR_COVER_CROP_SCALER_CORE_DEFINES_SVH
`define BILINEAR_COVER_CROP_SCALER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bccs_pkg.sv
// Shared widths, codes, defaults and colour helpers for the scaler core.
package bccs_pkg;

    localparam int OP_W  = 1;
    localparam int IDX_W = 13;
    localparam int PIX_W = 16;
    localparam int DX_W  = 9;
    localparam int DY_W  = 8;

    localparam int ART_SIDE_DEF   = 80;
    localparam int OUT_WIDTH_DEF  = 320;
    localparam int OUT_HEIGHT_DEF = 240;

    localparam logic [OP_W-1:0] OP_STORE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb888;

    // RGB565 to 8-bit channels by bit replication
    function automatic t_rgb888 expand565(input logic [PIX_W-1:0] c);
        t_rgb888 e;
        e.r = {c[15:11], c[15:13]};
        e.g = {c[10:5],  c[10:9]};
        e.b = {c[4:0],   c[4:2]};
        return e;
    endfunction

    function automatic logic [PIX_W-1:0] pack565(input t_rgb888 c);
        return {c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

endpackage

### rtl/core/bccs_stream_if.sv
// Valid/ready stream interfaces for input items and result pixels.
interface bccs_in_if;
    import bccs_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] art_index;
    logic [PIX_W-1:0] art_pixel;
    logic [DX_W-1:0]  dest_x;
    logic [DY_W-1:0]  dest_y;

    modport source (output valid, operation, art_index, art_pixel, dest_x, dest_y,
                    input ready);
    modport sink   (input valid, operation, art_index, art_pixel, dest_x, dest_y,
                    output ready);
endinterface

interface bccs_out_if;
    import bccs_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgb565;
    logic [DX_W-1:0]  out_x;
    logic [DY_W-1:0]  out_y;

    modport source (output valid, pixel_rgb565, out_x, out_y, input ready);
    modport sink   (input valid, pixel_rgb565, out_x, out_y, output ready);
endinterface

### rtl/core/bccs_ram.sv
// Generic RAM, one write port and two registered read ports.
module bccs_ram #(
    parameter int  WIDTH = bccs_pkg::PIX_W,
    parameter int  DEPTH = bccs_pkg::ART_SIDE_DEF * bccs_pkg::ART_SIDE_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### rtl/core/bilinear_cover_crop_scaler_core.sv
// Top level of the bilinear cover-crop RGB565 scaler core.
// A sample item passes through stages 1 to 9 in order; stage 9 is the output.
// Throughput: one item per cycle while the output is not stalled, stores and
// samples alike; set by the nine-stage pipeline and by two RAM copies that give
// four neighbour reads per cycle. Reset clears the stage valid bits only; the
// source image is undefined until stored, and there is no clearing pass.
`include "bilinear_cover_crop_scaler_core_defines.svh"

module bilinear_cover_crop_scaler_core #(
    parameter int ART_SIDE   = bccs_pkg::ART_SIDE_DEF,
    parameter int OUT_WIDTH  = bccs_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = bccs_pkg::OUT_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bccs_in_if.sink     i_in,
    bccs_out_if.source  o_out
);
    import bccs_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    //   M     cover length, the longer panel side
    //   NW    width of the pre-scale numerator n = 2d + M - L
    //   PW    width of N = n * ART_SIDE for an in-range coordinate (n < 2M)
    //   RECIP floor(2^(15+PW) / M); q = floor(N * 2^15 / M) is estimated as
    //         (N * RECIP) >> PW, which is low by at most one, then corrected
    //   KW    working width of the Q8.16 coordinate
    // ------------------------------------------------------------------
    localparam int M     = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
    localparam int DEPTH = ART_SIDE * ART_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(ART_SIDE);
    localparam int SVW   = $clog2(ART_SIDE + 1);
    localparam int NW    = $clog2(2 * (1 << DX_W) + 2 * M);
    localparam int PW    = $clog2(2 * M * ART_SIDE);
    localparam longint unsigned RECIP = (64'd1 << (15 + PW)) / M;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int MW    = $clog2(M + 1);
    localparam int QW    = 16 + SW;
    localparam int KW    = ((RW > QW) ? RW : QW) + 1;
    localparam int EW    = PW + 16;
    localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

    localparam logic [RW-1:0]  RECIP_C = RW'(RECIP);
    localparam logic [MW-1:0]  M_C     = MW'(M);
    localparam logic [SVW-1:0] SIDE_C  = SVW'(ART_SIDE);
    localparam logic [SW-1:0]  LAST_C  = SW'(ART_SIDE - 1);

    // ------------------------------------------------------------------
    // Stall control: a stage loads when it is empty or its successor loads.
    // Valid bits travel with the data; stores leave the pipe at the RAM stage.
    // ------------------------------------------------------------------
    logic [9:1] r_vld;
    logic [9:1] en;

    always_comb begin
        en[9] = !r_vld[9] || o_out.ready;
        for (int k = 8; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];

    // ------------------------------------------------------------------
    // Stage 1: numerator, saturation test and scale by ART_SIDE
    // ------------------------------------------------------------------
    logic [NW-1:0]     lin_x, lin_y;
    logic              sat_x, sat_y;
    logic [NW+SVW-1:0] scl_x, scl_y;
    logic [PW-1:0]     n_s1_nx, n_s1_ny;

    always_comb begin
        lin_x   = NW'({i_in.dest_x, 1'b0}) + NW'(M - OUT_WIDTH);
        lin_y   = NW'({i_in.dest_y, 1'b0}) + NW'(M - OUT_HEIGHT);
        // integer part reaches ART_SIDE exactly when n >= 2M
        sat_x   = lin_x >= NW'(2 * M);
        sat_y   = lin_y >= NW'(2 * M);
        scl_x   = lin_x * SIDE_C;
        scl_y   = lin_y * SIDE_C;
        n_s1_nx = sat_x ? '0 : PW'(scl_x);
        n_s1_ny = sat_y ? '0 : PW'(scl_y);
    end

    logic [OP_W-1:0]  r_s1_op;
    logic [IDX_W-1:0] r_s1_idx;
    logic [PIX_W-1:0] r_s1_pix;
    logic [DX_W-1:0]  r_s1_dx;
    logic [DY_W-1:0]  r_s1_dy;
    logic             r_s1_satx, r_s1_saty;
    logic [PW-1:0]    r_s1_nx, r_s1_ny;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_op   <= i_in.operation;
            r_s1_idx  <= i_in.art_index;
            r_s1_pix  <= i_in.art_pixel;
            r_s1_dx   <= i_in.dest_x;
            r_s1_dy   <= i_in.dest_y;
            r_s1_satx <= sat_x;
            r_s1_saty <= sat_y;
            r_s1_nx   <= n_s1_nx;
            r_s1_ny   <= n_s1_ny;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient estimate by reciprocal multiply
    // ------------------------------------------------------------------
    logic [PW+RW-1:0] prod_x, prod_y;

    assign prod_x = r_s1_nx * RECIP_C;
    assign prod_y = r_s1_ny * RECIP_C;

    logic [OP_W-1:0]  r_s2_op;
    logic [IDX_W-1:0] r_s2_idx;
    logic [PIX_W-1:0] r_s2_pix;
    logic [DX_W-1:0]  r_s2_dx;
    logic [DY_W-1:0]  r_s2_dy;
    logic             r_s2_satx, r_s2_saty;
    logic [PW-1:0]    r_s2_nx, r_s2_ny;
    logic [KW-1:0]    r_s2_qex, r_s2_qey;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_op   <= r_s1_op;
            r_s2_idx  <= r_s1_idx;
            r_s2_pix  <= r_s1_pix;
            r_s2_dx   <= r_s1_dx;
            r_s2_dy   <= r_s1_dy;
            r_s2_satx <= r_s1_satx;
            r_s2_saty <= r_s1_saty;
            r_s2_nx   <= r_s1_nx;
            r_s2_ny   <= r_s1_ny;
            r_s2_qex  <= KW'(prod_x >> PW);
            r_s2_qey  <= KW'(prod_y >> PW);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: back-multiply the estimate for the remainder check
    // ------------------------------------------------------------------
    logic [KW+MW-1:0] pm_x, pm_y;

    assign pm_x = r_s2_qex * M_C;
    assign pm_y = r_s2_qey * M_C;

    logic [OP_W-1:0]  r_s3_op;
    logic [IDX_W-1:0] r_s3_idx;
    logic [PIX_W-1:0] r_s3_pix;
    logic [DX_W-1:0]  r_s3_dx;
    logic [DY_W-1:0]  r_s3_dy;
    logic             r_s3_satx, r_s3_saty;
    logic [PW-1:0]    r_s3_nx, r_s3_ny;
    logic [KW-1:0]    r_s3_qex, r_s3_qey;
    logic [EW-1:0]    r_s3_pmx, r_s3_pmy;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_op   <= r_s2_op;
            r_s3_idx  <= r_s2_idx;
            r_s3_pix  <= r_s2_pix;
            r_s3_dx   <= r_s2_dx;
            r_s3_dy   <= r_s2_dy;
            r_s3_satx <= r_s2_satx;
            r_s3_saty <= r_s2_saty;
            r_s3_nx   <= r_s2_nx;
            r_s3_ny   <= r_s2_ny;
            r_s3_qex  <= r_s2_qex;
            r_s3_qey  <= r_s2_qey;
            r_s3_pmx  <= EW'(pm_x);
            r_s3_pmy  <= EW'(pm_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the estimate (remainder >= M means one more), then
    // split into integer part and 8-bit fraction, or saturate
    // ------------------------------------------------------------------
    logic [EW-1:0] lhs_x, lhs_y, rhs_x, rhs_y;
    logic [KW-1:0] q_x, q_y;
    logic [SW-1:0] n_s4_x0, n_s4_y0;
    logic [7:0]    n_s4_fx, n_s4_fy;

    always_comb begin
        lhs_x = EW'({r_s3_nx, 15'd0});
        lhs_y = EW'({r_s3_ny, 15'd0});
        rhs_x = r_s3_pmx + EW'(M);
        rhs_y = r_s3_pmy + EW'(M);
        q_x   = r_s3_qex + KW'(lhs_x >= rhs_x);
        q_y   = r_s3_qey + KW'(lhs_y >= rhs_y);
        n_s4_x0 = r_s3_satx ? LAST_C : q_x[16 +: SW];
        n_s4_y0 = r_s3_saty ? LAST_C : q_y[16 +: SW];
        n_s4_fx = r_s3_satx ? 8'd0 : q_x[15:8];
        n_s4_fy = r_s3_saty ? 8'd0 : q_y[15:8];
    end

    logic [OP_W-1:0]  r_s4_op;
    logic [IDX_W-1:0] r_s4_idx;
    logic [PIX_W-1:0] r_s4_pix;
    logic [DX_W-1:0]  r_s4_dx;
    logic [DY_W-1:0]  r_s4_dy;
    logic [SW-1:0]    r_s4_x0, r_s4_y0;
    logic [7:0]       r_s4_fx, r_s4_fy;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_op  <= r_s3_op;
            r_s4_idx <= r_s3_idx;
            r_s4_pix <= r_s3_pix;
            r_s4_dx  <= r_s3_dx;
            r_s4_dy  <= r_s3_dy;
            r_s4_x0  <= n_s4_x0;
            r_s4_y0  <= n_s4_y0;
            r_s4_fx  <= n_s4_fx;
            r_s4_fy  <= n_s4_fy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: edge clamp of the second neighbour, linear addresses, and
    // the store address with its range check
    // ------------------------------------------------------------------
    logic [SW-1:0]     x1, y1;
    logic [SW+SVW-1:0] row0, row1;
    logic [XW-1:0]     idx_ext;
    logic              idx_ok;

    always_comb begin
        x1      = (r_s4_x0 == LAST_C) ? r_s4_x0 : r_s4_x0 + SW'(1);
        y1      = (r_s4_y0 == LAST_C) ? r_s4_y0 : r_s4_y0 + SW'(1);
        row0    = r_s4_y0 * SIDE_C;
        row1    = y1 * SIDE_C;
        idx_ext = XW'(r_s4_idx);
        idx_ok  = int'(r_s4_idx) < DEPTH;
    end

    logic [OP_W-1:0]  r_s5_op;
    logic             r_s5_wen;
    logic [AW-1:0]    r_s5_waddr;
    logic [PIX_W-1:0] r_s5_pix;
    logic [DX_W-1:0]  r_s5_dx;
    logic [DY_W-1:0]  r_s5_dy;
    logic [7:0]       r_s5_fx, r_s5_fy;
    logic [AW-1:0]    r_s5_a00, r_s5_a10, r_s5_a01, r_s5_a11;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_op    <= r_s4_op;
            r_s5_wen   <= (r_s4_op == OP_STORE) && idx_ok;
            r_s5_waddr <= idx_ext[AW-1:0];
            r_s5_pix   <= r_s4_pix;
            r_s5_dx    <= r_s4_dx;
            r_s5_dy    <= r_s4_dy;
            r_s5_fx    <= r_s4_fx;
            r_s5_fy    <= r_s4_fy;
            r_s5_a00   <= AW'(row0) + AW'(r_s4_x0);
            r_s5_a10   <= AW'(row0) + AW'(x1);
            r_s5_a01   <= AW'(row1) + AW'(r_s4_x0);
            r_s5_a11   <= AW'(row1) + AW'(x1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: image store. Two copies, each written by every in-range store and
    // read at two addresses, give the four neighbours together. A store writes
    // as it moves on from stage 5, so later samples always see it.
    // ------------------------------------------------------------------
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] rd00, rd10, rd01, rd11;

    assign ram_we = en[6] && r_vld[5] && r_s5_wen;
    assign ram_re = en[6] && r_vld[5] && (r_s5_op == OP_SAMPLE);

    bccs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram_top (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_s5_waddr),
        .i_wdata   (r_s5_pix),
        .i_re      (ram_re),
        .i_raddr_a (r_s5_a00),
        .i_raddr_b (r_s5_a10),
        .o_rdata_a (rd00),
        .o_rdata_b (rd10)
    );

    bccs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram_bot (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_s5_waddr),
        .i_wdata   (r_s5_pix),
        .i_re      (ram_re),
        .i_raddr_a (r_s5_a01),
        .i_raddr_b (r_s5_a11),
        .o_rdata_a (rd01),
        .o_rdata_b (rd11)
    );

    logic [DX_W-1:0] r_s6_dx;
    logic [DY_W-1:0] r_s6_dy;
    logic [7:0]      r_s6_fx, r_s6_fy;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_dx <= r_s5_dx;
            r_s6_dy <= r_s5_dy;
            r_s6_fx <= r_s5_fx;
            r_s6_fy <= r_s5_fy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: channel expansion and bilinear weights (sum 65536)
    // Neighbour order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    // ------------------------------------------------------------------
    logic [8:0]  fxc, fyc;
    logic [17:0] wp [4];

    always_comb begin
        fxc   = 9'd256 - {1'b0, r_s6_fx};
        fyc   = 9'd256 - {1'b0, r_s6_fy};
        wp[0] = fxc * fyc;
        wp[1] = r_s6_fx * fyc;
        wp[2] = fxc * r_s6_fy;
        wp[3] = r_s6_fx * r_s6_fy;
    end

    logic [DX_W-1:0] r_s7_dx;
    logic [DY_W-1:0] r_s7_dy;
    t_rgb888         r_s7_ch [4];
    logic [16:0]     r_s7_w [4];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_dx    <= r_s6_dx;
            r_s7_dy    <= r_s6_dy;
            r_s7_ch[0] <= expand565(rd00);
            r_s7_ch[1] <= expand565(rd10);
            r_s7_ch[2] <= expand565(rd01);
            r_s7_ch[3] <= expand565(rd11);
            for (int j = 0; j < 4; j++) begin
                r_s7_w[j] <= wp[j][16:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: twelve channel-by-weight products
    // ------------------------------------------------------------------
    logic [DX_W-1:0] r_s8_dx;
    logic [DY_W-1:0] r_s8_dy;
    logic [24:0]     r_s8_pr [4];
    logic [24:0]     r_s8_pg [4];
    logic [24:0]     r_s8_pb [4];

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_dx <= r_s7_dx;
            r_s8_dy <= r_s7_dy;
            for (int j = 0; j < 4; j++) begin
                r_s8_pr[j] <= r_s7_ch[j].r * r_s7_w[j];
                r_s8_pg[j] <= r_s7_ch[j].g * r_s7_w[j];
                r_s8_pb[j] <= r_s7_ch[j].b * r_s7_w[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: sums, truncate by 16 bits, repack; this is the output register
    // ------------------------------------------------------------------
    logic [26:0] sum_r, sum_g, sum_b;
    t_rgb888     blend;

    always_comb begin
        sum_r   = 27'(r_s8_pr[0]) + 27'(r_s8_pr[1]) + 27'(r_s8_pr[2]) + 27'(r_s8_pr[3]);
        sum_g   = 27'(r_s8_pg[0]) + 27'(r_s8_pg[1]) + 27'(r_s8_pg[2]) + 27'(r_s8_pg[3]);
        sum_b   = 27'(r_s8_pb[0]) + 27'(r_s8_pb[1]) + 27'(r_s8_pb[2]) + 27'(r_s8_pb[3]);
        blend.r = sum_r[23:16];
        blend.g = sum_g[23:16];
        blend.b = sum_b[23:16];
    end

    logic [PIX_W-1:0] r_s9_pix;
    logic [DX_W-1:0]  r_s9_dx;
    logic [DY_W-1:0]  r_s9_dy;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_s9_pix <= pack565(blend);
            r_s9_dx  <= r_s8_dx;
            r_s9_dy  <= r_s8_dy;
        end
    end

    assign o_out.valid        = r_vld[9];
    assign o_out.pixel_rgb565 = r_s9_pix;
    assign o_out.out_x        = r_s9_dx;
    assign o_out.out_y        = r_s9_dy;

    // ------------------------------------------------------------------
    // Valid bits; a store drops out once it has written the image
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= 9; k++) begin
                if (en[k]) begin
                    if (k == 6) begin
                        r_vld[k] <= r_vld[k-1] && (r_s5_op == OP_SAMPLE);
                    end else begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BCCS_ASSERT_SAME(a_addr_in_range, i_clk, i_rst_n,
        r_vld[5] && (r_s5_op == OP_SAMPLE),
        (int'(r_s5_a00) < DEPTH) && (int'(r_s5_a11) < DEPTH),
        "neighbour address beyond the image")
    `BCCS_ASSERT_SAME(a_weight_sum, i_clk, i_rst_n,
        r_vld[7],
        (18'(r_s7_w[0]) + 18'(r_s7_w[1]) + 18'(r_s7_w[2]) + 18'(r_s7_w[3])) == 18'h10000,
        "bilinear weights do not sum to one")
    `BCCS_ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n,
        r_vld[6] && !en[6],
        $stable(rd00) && $stable(rd10) && $stable(rd01) && $stable(rd11),
        "stalled neighbour data changed")

endmodule

### dv/bilinear_cover_crop_scaler_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear cover-crop RGB565 scaler core.
module bilinear_cover_crop_scaler_core_tb;
    import bccs_pkg::*;

    // Core parameters as instantiated below
    localparam int ART   = ART_SIDE_DEF;
    localparam int OUT_W = OUT_WIDTH_DEF;
    localparam int OUT_H = OUT_HEIGHT_DEF;
    localparam int COVER = (OUT_W > OUT_H) ? OUT_W : OUT_H;

    // Input transfer to result transfer when no stage stalls
    localparam int LATENCY = 9;
    // Cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT = 4000;
    // Useful input transfers wanted in the random part
    localparam int TARGET_ITEMS = 1350;
    // Idle percentage on both sides outside the calm stretch
    localparam int IDLE_PCT = 29;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
        logic [DX_W-1:0]  dx;
        logic [DY_W-1:0]  dy;
    } t_scaler_item;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [DX_W-1:0]  x;
        logic [DY_W-1:0]  y;
    } t_scaler_pixel;

    // Own copy of the source image, plus which entries have been stored since
    // reset. Every sample is predicted here and queued until the core answers.
    class cover_crop_predictor;
        logic [PIX_W-1:0] image [ART*ART];
        bit               written [ART*ART];
        t_scaler_pixel    expected_pixels [$];
        int               mismatches = 0;

        // Unsigned Q8.16 source coordinate, saturated to the last pixel
        function logic [31:0] src_q(int unsigned d, int unsigned len);
            longint unsigned dl, ll, num, q;
            dl  = d;
            ll  = len;
            num = (2 * dl + COVER - ll) * ART;
            q   = (num << 16) / (2 * COVER);
            if ((q >> 16) >= ART)
                q = longint'(ART - 1) << 16;
            return q[31:0];
        endfunction

        // Linear indexes of the four neighbours, with edge clamping, and fractions
        function void corners(input logic [DX_W-1:0] dx, input logic [DY_W-1:0] dy,
                              output int unsigned idx [4],
                              output int unsigned fx, output int unsigned fy);
            logic [31:0] qx, qy;
            int unsigned x0, x1, y0, y1;
            qx = src_q(dx, OUT_W);
            qy = src_q(dy, OUT_H);
            x0 = qx >> 16;
            y0 = qy >> 16;
            fx = (qx >> 8) & 8'hFF;
            fy = (qy >> 8) & 8'hFF;
            x1 = (x0 + 1 < ART) ? x0 + 1 : x0;
            y1 = (y0 + 1 < ART) ? y0 + 1 : y0;
            idx[0] = y0 * ART + x0;
            idx[1] = y0 * ART + x1;
            idx[2] = y1 * ART + x0;
            idx[3] = y1 * ART + x1;
        endfunction

        function bit covered(logic [DX_W-1:0] dx, logic [DY_W-1:0] dy);
            int unsigned idx [4];
            int unsigned fx, fy;
            corners(dx, dy, idx, fx, fy);
            return written[idx[0]] && written[idx[1]] && written[idx[2]] && written[idx[3]];
        endfunction

        // Channel k (0 red, 1 green, 2 blue) widened to 8 bits
        function int unsigned widen(logic [PIX_W-1:0] p, int k);
            int unsigned v;
            if (k == 1) begin
                v = (p >> 5) & 6'h3F;
                return (v << 2) | (v >> 4);
            end
            v = (k == 0) ? (p >> 11) & 5'h1F : p & 5'h1F;
            return (v << 3) | (v >> 2);
        endfunction

        function void take_item(t_scaler_item it);
            int unsigned   idx [4];
            int unsigned   fx, fy, s;
            int unsigned   w [4];
            logic [7:0]    ch [3];
            t_scaler_pixel e;
            if (it.op == OP_STORE) begin
                if (it.idx < ART * ART) begin
                    image[it.idx]   = it.pix;
                    written[it.idx] = 1'b1;
                end
                return;
            end
            corners(it.dx, it.dy, idx, fx, fy);
            w[0] = (256 - fx) * (256 - fy);
            w[1] = fx * (256 - fy);
            w[2] = (256 - fx) * fy;
            w[3] = fx * fy;
            for (int k = 0; k < 3; k++) begin
                s = 0;
                for (int n = 0; n < 4; n++)
                    s += widen(image[idx[n]], k) * w[n];
                ch[k] = 8'(s >> 16);
            end
            e.pixel = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
            e.x     = it.dx;
            e.y     = it.dy;
            expected_pixels.push_back(e);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pixel, logic [DX_W-1:0] x,
                                  logic [DY_W-1:0] y);
            t_scaler_pixel e;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result pixel %h at (%0d,%0d)", pixel, x, y);
                mismatches++;
                return;
            end
            e = expected_pixels.pop_front();
            if (pixel !== e.pixel) begin
                $error("pixel_rgb565: expected %h, actual %h", e.pixel, pixel);
                mismatches++;
            end
            if (x !== e.x) begin
                $error("out_x: expected %0d, actual %0d", e.x, x);
                mismatches++;
            end
            if (y !== e.y) begin
                $error("out_y: expected %0d, actual %0d", e.y, y);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bccs_in_if  in_if ();
    bccs_out_if out_if ();

    bilinear_cover_crop_scaler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    cover_crop_predictor book = new();

    bit calm = 1'b0;       // set during the stretch with no idling on either side
    int useful_items = 0;  // input transfers that are not ignored stores
    int hang_cycles = 0;

    always #4 i_clk = ~i_clk;

    // Result side: random back-pressure, none while calm
    always @(posedge i_clk) begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            book.check_pixel(out_if.pixel_rgb565, out_if.out_x, out_if.out_y);
    end

    // Hang detection: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
        if (hang_cycles >= HANG_LIMIT) begin
            $display("[bilinear_cover_crop_scaler_core] ERROR");
            $finish;
        end
    end

    // One input transfer. Gaps are decided before valid goes high so that
    // valid gets a single assignment per time step.
    task automatic send_item(t_scaler_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= it.op;
        in_if.art_index <= it.idx;
        in_if.art_pixel <= it.pix;
        in_if.dest_x    <= it.dx;
        in_if.dest_y    <= it.dy;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        book.take_item(it);
        if (!(it.op == OP_STORE && it.idx >= ART * ART))
            useful_items++;
    endtask

    // Store; the destination fields carry random noise
    task automatic send_store(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix);
        t_scaler_item it;
        it.op  = OP_STORE;
        it.idx = idx;
        it.pix = pix;
        it.dx  = DX_W'($urandom_range(511));
        it.dy  = DY_W'($urandom_range(255));
        send_item(it);
    endtask

    // Sample; the store fields carry random noise
    task automatic send_sample(logic [DX_W-1:0] dx, logic [DY_W-1:0] dy);
        t_scaler_item it;
        it.op  = OP_SAMPLE;
        it.idx = IDX_W'($urandom_range(8191));
        it.pix = PIX_W'($urandom_range(65535));
        it.dx  = dx;
        it.dy  = dy;
        send_item(it);
    endtask

    // Stores the neighbourhood of a destination pixel. Without rewrite, only
    // entries not yet written are stored, plus some at random.
    task automatic fill_corners(logic [DX_W-1:0] dx, logic [DY_W-1:0] dy, bit rewrite,
                                logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                                logic [PIX_W-1:0] p2, logic [PIX_W-1:0] p3);
        int unsigned      idx [4];
        int unsigned      fx, fy;
        logic [PIX_W-1:0] pv [4];
        pv = '{p0, p1, p2, p3};
        book.corners(dx, dy, idx, fx, fy);
        for (int n = 0; n < 4; n++) begin
            if (rewrite || !book.written[idx[n]] || $urandom_range(2) == 0)
                send_store(IDX_W'(idx[n]), pv[n]);
        end
    endtask

    initial begin
        logic [DX_W-1:0] dx;
        logic [DY_W-1:0] dy;
        int              pick;

        in_if.valid     <= 1'b0;
        in_if.operation <= OP_STORE;
        in_if.art_index <= '0;
        in_if.art_pixel <= '0;
        in_if.dest_x    <= '0;
        in_if.dest_y    <= '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ----
        // Stores beyond the image are ignored
        send_store(13'h1FFF, 16'hFFFF);
        send_store(IDX_W'(ART * ART), 16'hA5A5);
        // First and last valid entries
        send_store('0, 16'hFFFF);
        send_store(IDX_W'(ART * ART - 1), 16'h1234);

        // Top-left of the panel: white, black, pure red, pure green corners,
        // sampled at zero fraction and at fractions of a quarter and three quarters
        fill_corners('0, '0, 1'b1, 16'hFFFF, 16'h0000, 16'hF800, 16'h07E0);
        send_sample(9'd0, 8'd0);
        send_sample(9'd1, 8'd0);
        send_sample(9'd0, 8'd1);
        send_sample(9'd3, 8'd3);

        // Store immediately followed by a sample that reads it
        fill_corners('0, '0, 1'b1, 16'h001F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(9'd0, 8'd0);

        // Largest destination, well outside the panel
        fill_corners(9'd511, 8'd255, 1'b1, 16'h001F, 16'hFFFF, 16'h0000, 16'h8410);
        send_sample(9'd511, 8'd255);
        send_sample(9'd504, 8'd252);

        // Bottom-right pixel of the panel, right neighbour clamped
        fill_corners(DX_W'(OUT_W - 1), DY_W'(OUT_H - 1), 1'b1,
                     16'h7BEF, 16'hF81F, 16'h07FF, 16'hFFE0);
        send_sample(DX_W'(OUT_W - 1), DY_W'(OUT_H - 1));

        // ---- Random part ----
        // Mostly fill a neighbourhood then sample it; the rest is stray stores (in
        // and out of range), incomplete neighbourhoods and samples of covered ones.
        useful_items = 0;
        while (useful_items < TARGET_ITEMS) begin
            calm = (useful_items >= 600 && useful_items < 800);
            if ($urandom_range(1) == 0) begin
                dx = DX_W'($urandom_range(OUT_W - 1));
                dy = DY_W'($urandom_range(OUT_H - 1));
            end else begin
                dx = DX_W'($urandom_range(511));
                dy = DY_W'($urandom_range(255));
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                fill_corners(dx, dy, 1'b0,
                             PIX_W'($urandom_range(65535)), PIX_W'($urandom_range(65535)),
                             PIX_W'($urandom_range(65535)), PIX_W'($urandom_range(65535)));
                send_sample(dx, dy);
                if ($urandom_range(2) == 0 && book.covered(dx ^ DX_W'(1), dy))
                    send_sample(dx ^ DX_W'(1), dy);
            end else if (pick < 85) begin
                send_store(IDX_W'($urandom_range(8191)), PIX_W'($urandom_range(65535)));
            end else if (pick < 93) begin
                // incomplete neighbourhood: stored, never sampled
                send_store(IDX_W'(dy * ART + (dx >> 3)), PIX_W'($urandom_range(65535)));
            end else if (book.covered(dx, dy)) begin
                send_sample(dx, dy);
            end else begin
                send_store(IDX_W'($urandom_range(ART * ART - 1)),
                           PIX_W'($urandom_range(65535)));
            end
        end
        calm = 1'b0;
        in_if.valid <= 1'b0;

        // Drain, then allow the pipeline depth for any stray result
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY * 3) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("[bilinear_cover_crop_scaler_core] OK");
        end else begin
            $display("[bilinear_cover_crop_scaler_core] ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bccs_pkg.sv
rtl/core/bccs_stream_if.sv
rtl/core/bccs_ram.sv
rtl/core/bilinear_cover_crop_scaler_core.sv
dv/bilinear_cover_crop_scaler_core_tb.sv
